// ===== rtl/dtq_pkg.sv =====
package dtq_pkg;

    // Number of waiter slots the queue can hold.
    localparam int MAX_THREADS = 16;

    localparam int IDX_W   = $clog2(MAX_THREADS);
    localparam int CNT_W   = $clog2(MAX_THREADS + 1);
    localparam int ID_W    = 4;
    localparam int DELAY_W = 31;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    // Operation codes of the input beat.
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes of the result beat.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_QUEUED = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    waiter_id;
        logic [DELAY_W-1:0] delay_ticks;
    } in_item_t;

    typedef struct packed {
        logic              expired_valid;
        logic [ID_W-1:0]   expired_id;
        logic [STAT_W-1:0] status;
        logic              last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_WALK,
        S_INS_PLACE,
        S_REM_FIND,
        S_REM_FIX,
        S_TICK_DEC,
        S_TICK_SCAN,
        S_RESP
    } state_t;

    // Request and response of the shared add/subtract unit.
    typedef struct packed {
        logic               sub;
        logic [DELAY_W-1:0] opa;
        logic [DELAY_W-1:0] opb;
    } alu_req_t;

    typedef struct packed {
        logic [DELAY_W-1:0] res;
        logic               carry;
    } alu_rsp_t;

endpackage

// ===== rtl/dtq_alu.sv =====
module dtq_alu
    import dtq_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    // On a subtract the carry out is set when opa is not below opb.
    logic [DELAY_W:0] sum;
    logic [DELAY_W-1:0] opb_eff;

    assign opb_eff = req.sub ? ~req.opb : req.opb;
    assign sum = {1'b0, req.opa} + {1'b0, opb_eff} + {{DELAY_W{1'b0}}, req.sub};

    assign rsp.res   = sum[DELAY_W-1:0];
    assign rsp.carry = sum[DELAY_W];

endmodule

// ===== rtl/delta_timeout_queue.sv =====
// Delta-list timeout queue for waiter slots.
//
// The input channel (s_valid, s_ready, s_item) takes one beat per command:
// a tick, an insert of a waiter with a delay in ticks, or a remove. Each
// queued entry holds its delay relative to the entry in front of it, so a
// tick only touches the head. The result channel (m_valid, m_ready, m_item)
// gives one beat for an insert, a remove or an unused op code, carrying the
// status. A tick gives one beat per expired waiter in queue order, with last
// set on the final one, or a single empty beat when nothing expires.
//
// The block works on one command at a time and s_ready is low meanwhile.
// All delay arithmetic goes through one shared 31-bit add/subtract unit. An
// insert that stops its walk at position P (at most N for N queued entries)
// walks the list entry by entry, then places the entry and loads its
// result. A remove likewise walks to the entry at position P, closes the
// gap and loads its result. A tick first decrements a nonzero head delta,
// then loads one beat per expired waiter. s_ready rises again together with
// the loading of the final beat; the next command is taken in the idle state.
// A stalled receiver holds the result register and the sequencer waits on
// it; nothing is lost or repeated.
// After reset the queue is empty and no result is pending; the entry store
// is not cleared, since only positions below the entry count are read.
module delta_timeout_queue
    import dtq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    state_t state_reg, state_next;

    // Ordered entry store: waiter id and delta relative to the predecessor.
    logic [ID_W-1:0]    id_reg     [MAX_THREADS];
    logic [ID_W-1:0]    id_next    [MAX_THREADS];
    logic [DELAY_W-1:0] delta_reg  [MAX_THREADS];
    logic [DELAY_W-1:0] delta_next [MAX_THREADS];

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [MAX_THREADS-1:0] flag_reg, flag_next;

    // Working registers of the command in progress.
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [DELAY_W-1:0] rem_reg, rem_next;
    logic [ID_W-1:0]    wid_reg, wid_next;
    logic [STAT_W-1:0]  stat_reg, stat_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    logic [CNT_W-1:0]   idx1;
    logic [IDX_W-1:0]   pos;
    logic [IDX_W-1:0]   rd_sel;
    logic [DELAY_W-1:0] rd_delta;
    logic               out_free;
    logic               accept;
    logic               in_id_ok;
    logic [IDX_W-1:0]   in_slot;
    logic               walk_done;
    logic               id_match;
    logic               expiring;
    logic               exp_last;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    dtq_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign idx1     = idx_reg + CNT_W'(1);
    assign pos      = idx_reg[IDX_W-1:0];
    assign in_id_ok = (32'(s_item.waiter_id) < 32'(MAX_THREADS));
    assign in_slot  = IDX_W'(s_item.waiter_id);

    // A read port on the delta store, addressed by the sequencer.
    always_comb begin
        unique case (state_reg)
            S_REM_FIX:  rd_sel = idx1[IDX_W-1:0];
            S_TICK_DEC: rd_sel = '0;
            default:    rd_sel = pos;
        endcase
    end

    assign rd_delta = delta_reg[rd_sel];
    assign id_match = (id_reg[pos] == wid_reg);

    // Operand selection for the shared unit.
    always_comb begin
        alu_req.sub = 1'b1;
        alu_req.opa = rem_reg;
        alu_req.opb = rd_delta;
        unique case (state_reg)
            S_INS_PLACE: begin
                alu_req.opa = rd_delta;
                alu_req.opb = rem_reg;
            end
            S_REM_FIX: begin
                alu_req.sub = 1'b0;
                alu_req.opa = rd_delta;
                alu_req.opb = rem_reg;
            end
            S_TICK_DEC: begin
                alu_req.opa = rd_delta;
                alu_req.opb = DELAY_W'(1);
            end
            default: begin
                alu_req.opa = rem_reg;
                alu_req.opb = rd_delta;
            end
        endcase
    end

    // The walk stops at the end of the list or where the remainder would
    // go negative.
    assign walk_done = (idx_reg == count_reg) || !alu_rsp.carry;
    assign expiring  = (count_reg != '0) && (delta_reg[0] == '0);
    assign exp_last  = (count_reg == CNT_W'(1)) || (delta_reg[1] != '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_item.op)
                        OP_TICK: state_next = S_TICK_DEC;
                        OP_INSERT: begin
                            if (!in_id_ok || flag_reg[in_slot] ||
                                count_reg >= CNT_W'(MAX_THREADS)) begin
                                state_next = S_RESP;
                            end else begin
                                state_next = S_INS_WALK;
                            end
                        end
                        OP_REMOVE: begin
                            if (!in_id_ok || !flag_reg[in_slot]) begin
                                state_next = S_RESP;
                            end else begin
                                state_next = S_REM_FIND;
                            end
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_INS_WALK: begin
                if (walk_done) begin
                    state_next = S_INS_PLACE;
                end
            end
            S_INS_PLACE: state_next = S_RESP;
            S_REM_FIND: begin
                if (idx_reg == count_reg) begin
                    state_next = S_RESP;
                end else if (id_match) begin
                    state_next = S_REM_FIX;
                end
            end
            S_REM_FIX:  state_next = S_RESP;
            S_TICK_DEC: state_next = S_TICK_SCAN;
            S_TICK_SCAN: begin
                if (out_free && (!expiring || exp_last)) begin
                    state_next = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and result register.
    always_comb begin
        id_next      = id_reg;
        delta_next   = delta_reg;
        count_next   = count_reg;
        flag_next    = flag_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        wid_next     = wid_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    idx_next  = '0;
                    rem_next  = s_item.delay_ticks;
                    wid_next  = s_item.waiter_id;
                    stat_next = ST_OK;
                    if (s_item.op == OP_INSERT && (!in_id_ok || flag_reg[in_slot] ||
                        count_reg >= CNT_W'(MAX_THREADS))) begin
                        stat_next = ST_QUEUED;
                    end
                    if (s_item.op == OP_REMOVE && (!in_id_ok || !flag_reg[in_slot])) begin
                        stat_next = ST_ABSENT;
                    end
                end
            end
            S_INS_WALK: begin
                if (!walk_done) begin
                    rem_next = alu_rsp.res;
                    idx_next = idx1;
                end
            end
            S_INS_PLACE: begin
                for (int j = 1; j < MAX_THREADS; j++) begin
                    if (CNT_W'(j) > idx_reg && CNT_W'(j) <= count_reg) begin
                        id_next[j]    = id_reg[j-1];
                        delta_next[j] = delta_reg[j-1];
                    end
                end
                id_next[pos]    = wid_reg;
                delta_next[pos] = rem_reg;
                if (idx_reg < count_reg) begin
                    delta_next[idx1[IDX_W-1:0]] = alu_rsp.res;
                end
                count_next                 = count_reg + CNT_W'(1);
                flag_next[IDX_W'(wid_reg)] = 1'b1;
            end
            S_REM_FIND: begin
                if (idx_reg == count_reg) begin
                    stat_next = ST_ABSENT;
                end else if (id_match) begin
                    rem_next = rd_delta;
                end else begin
                    idx_next = idx1;
                end
            end
            S_REM_FIX: begin
                // Close the gap; the successor inherits the removed delta.
                for (int j = 0; j < MAX_THREADS - 1; j++) begin
                    if (CNT_W'(j) >= idx_reg) begin
                        id_next[j]    = id_reg[j+1];
                        delta_next[j] = delta_reg[j+1];
                    end
                end
                if (idx1 < count_reg) begin
                    delta_next[pos] = alu_rsp.res;
                end
                count_next                 = count_reg - CNT_W'(1);
                flag_next[IDX_W'(wid_reg)] = 1'b0;
            end
            S_TICK_DEC: begin
                if (count_reg != '0 && delta_reg[0] != '0) begin
                    delta_next[0] = alu_rsp.res;
                end
            end
            S_TICK_SCAN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (expiring) begin
                        m_item_next.expired_valid = 1'b1;
                        m_item_next.expired_id    = id_reg[0];
                        m_item_next.status        = ST_OK;
                        m_item_next.last          = exp_last;
                        for (int j = 0; j < MAX_THREADS - 1; j++) begin
                            id_next[j]    = id_reg[j+1];
                            delta_next[j] = delta_reg[j+1];
                        end
                        count_next                   = count_reg - CNT_W'(1);
                        flag_next[IDX_W'(id_reg[0])] = 1'b0;
                    end else begin
                        m_item_next.expired_valid = 1'b0;
                        m_item_next.expired_id    = '0;
                        m_item_next.status        = ST_OK;
                        m_item_next.last          = 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_item_next.expired_valid = 1'b0;
                    m_item_next.expired_id    = '0;
                    m_item_next.status        = stat_reg;
                    m_item_next.last          = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            flag_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg     <= id_next;
        delta_reg  <= delta_next;
        idx_reg    <= idx_next;
        rem_reg    <= rem_next;
        wid_reg    <= wid_next;
        stat_reg   <= stat_next;
        m_item_reg <= m_item_next;
    end

    // The queued flags and the entry count must always describe the same set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(flag_reg) == int'(count_reg))
        else $error("queued flags disagree with entry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_THREADS))
        else $error("entry count beyond capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.expired_valid |-> m_item_reg.status == ST_OK)
        else $error("expiry beat carries an error status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_item_reg.last |-> m_item_reg.expired_valid)
        else $error("non-final beat that is not an expiry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("new command taken while one is in progress");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the delta-list timeout queue. Commands go in on the
// s_ channel in bursts, and result beats are taken off the m_ channel under a
// changing stall pattern. Every accepted command is run through a local model
// of the delta list, and each result beat is checked against the oldest
// expected beat.
module testbench;
    import dtq_pkg::*;

    // The op code that the block does not use; it must answer with an empty beat.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned SHOW_LIMIT   = 10;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    delta_timeout_queue uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Local copy of the delta list. Only positions below wl_count are ever
    // read, so the entries need no clearing.
    logic [ID_W-1:0]    wl_id    [MAX_THREADS];
    logic [DELAY_W-1:0] wl_delta [MAX_THREADS];
    int unsigned        wl_count = 0;
    bit                 wl_queued [MAX_THREADS] = '{default: 1'b0};

    // Result beats that the block still owes, oldest first.
    out_item_t due_beats[$];

    int unsigned cycle_count = 0;
    int unsigned fault_count = 0;
    int unsigned hold_left   = 0;
    int unsigned burst_left  = 0;
    out_item_t   oldest;

    // One row of the directed part. When has_want is set, the expected beat
    // is the one typed into the row; otherwise the model supplies it.
    typedef struct {
        in_item_t  cmd;
        bit        has_want;
        out_item_t want;
    } plan_row_t;

    function automatic in_item_t mk_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                        logic [DELAY_W-1:0] delay);
        in_item_t c;
        c.op          = op;
        c.waiter_id   = id;
        c.delay_ticks = delay;
        return c;
    endfunction

    function automatic out_item_t mk_beat(logic valid, logic [ID_W-1:0] id,
                                          logic [STAT_W-1:0] st, logic last);
        out_item_t b;
        b.expired_valid = valid;
        b.expired_id    = id;
        b.status        = st;
        b.last          = last;
        return b;
    endfunction

    // Applies one command to the local delta list and returns the beats it
    // should produce.
    function automatic void run_timer_list(input in_item_t cmd, ref out_item_t beats[$]);
        out_item_t          b;
        logic [DELAY_W-1:0] rem;
        int unsigned        pos;
        int unsigned        drop;
        int unsigned        j;
        b      = '0;
        b.last = 1'b1;
        beats.delete();
        case (cmd.op)
            OP_TICK: begin
                // Only the head carries time; once it is zero, every leading
                // zero-delta entry expires together.
                if (wl_count > 0 && wl_delta[0] != '0) begin
                    wl_delta[0] = wl_delta[0] - 1'b1;
                end
                drop = 0;
                while (drop < wl_count && wl_delta[drop] == '0) begin
                    b.expired_valid = 1'b1;
                    b.expired_id    = wl_id[drop];
                    b.status        = ST_OK;
                    b.last          = 1'b0;
                    wl_queued[wl_id[drop]] = 1'b0;
                    beats.push_back(b);
                    drop++;
                end
                for (pos = 0; pos + drop < wl_count; pos++) begin
                    wl_id[pos]    = wl_id[pos + drop];
                    wl_delta[pos] = wl_delta[pos + drop];
                end
                wl_count -= drop;
                if (beats.size() == 0) begin
                    b      = '0;
                    b.last = 1'b1;
                    beats.push_back(b);
                end else begin
                    b      = beats.pop_back();
                    b.last = 1'b1;
                    beats.push_back(b);
                end
            end
            OP_INSERT: begin
                // Ids are four bits wide, so every id is below the slot count.
                if (wl_queued[cmd.waiter_id] || wl_count >= MAX_THREADS) begin
                    b.status = ST_QUEUED;
                end else begin
                    rem = cmd.delay_ticks;
                    pos = 0;
                    while (pos < wl_count && rem >= wl_delta[pos]) begin
                        rem = rem - wl_delta[pos];
                        pos++;
                    end
                    if (pos < wl_count) begin
                        wl_delta[pos] = wl_delta[pos] - rem;
                    end
                    for (j = wl_count; j > pos; j--) begin
                        wl_id[j]    = wl_id[j - 1];
                        wl_delta[j] = wl_delta[j - 1];
                    end
                    wl_id[pos]    = cmd.waiter_id;
                    wl_delta[pos] = rem;
                    wl_count++;
                    wl_queued[cmd.waiter_id] = 1'b1;
                end
                beats.push_back(b);
            end
            OP_REMOVE: begin
                pos = 0;
                while (pos < wl_count && wl_id[pos] != cmd.waiter_id) begin
                    pos++;
                end
                if (!wl_queued[cmd.waiter_id] || pos >= wl_count) begin
                    b.status = ST_ABSENT;
                end else begin
                    // The successor inherits the removed delta so that later
                    // expiry times stay where they were.
                    if (pos + 1 < wl_count) begin
                        wl_delta[pos + 1] = wl_delta[pos + 1] + wl_delta[pos];
                    end
                    while (pos + 1 < wl_count) begin
                        wl_id[pos]    = wl_id[pos + 1];
                        wl_delta[pos] = wl_delta[pos + 1];
                        pos++;
                    end
                    wl_count--;
                    wl_queued[cmd.waiter_id] = 1'b0;
                end
                beats.push_back(b);
            end
            default: begin
                beats.push_back(b);
            end
        endcase
    endfunction

    // Mostly short delays so that ticks keep expiring entries, with some
    // long and some full-range ones to exercise every delay bit.
    function automatic logic [DELAY_W-1:0] pick_delay();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65) begin
            return DELAY_W'($urandom_range(6));
        end else if (r < 82) begin
            return DELAY_W'($urandom_range(40));
        end else if (r < 96) begin
            return DELAY_W'($urandom);
        end
        return {DELAY_W{1'b1}};
    endfunction

    // Drives one command beat, waits for it to be accepted, and records
    // what it should produce. Between bursts the sender goes quiet for a
    // random number of cycles; some bursts follow with no gap at all.
    task automatic send_cmd(in_item_t cmd, bit has_want, out_item_t want);
        out_item_t   beats[$];
        int unsigned gap;
        s_item  <= cmd;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        run_timer_list(cmd, beats);
        if (has_want) begin
            due_beats.push_back(want);
        end else begin
            foreach (beats[k]) due_beats.push_back(beats[k]);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Holds the sender off until every expected beat has been seen.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_beats.size() != 0) @(posedge aclk);
    endtask

    // The receiver's stall pattern steps through four phases, picked by bits 8:7
    // of the cycle count: always ready, coin flips, mostly stalled, and long alternating runs.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else begin
            case (cycle_count[8:7])
                2'd0: begin
                    m_ready <= 1'b1;
                end
                2'd1: begin
                    m_ready <= ($urandom_range(1) == 1);
                end
                2'd2: begin
                    m_ready   <= ($urandom_range(3) == 0);
                    hold_left <= $urandom_range(2);
                end
                default: begin
                    m_ready   <= ~m_ready;
                    hold_left <= $urandom_range(15);
                end
            endcase
        end
    end

    // Result checker. Each beat taken from the block is matched against the
    // oldest expected beat, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_beats.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT) begin
                    $display("%0t: unexpected result beat valid=%0d id=%0d status=%0d last=%0d",
                             $realtime, m_item.expired_valid, m_item.expired_id,
                             m_item.status, m_item.last);
                end
            end else begin
                oldest = due_beats.pop_front();
                if (m_item.expired_valid !== oldest.expired_valid ||
                    m_item.expired_id !== oldest.expired_id ||
                    m_item.status !== oldest.status ||
                    m_item.last !== oldest.last) begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT) begin
                        $display("%0t: result mismatch: expected valid=%0d id=%0d status=%0d last=%0d, got valid=%0d id=%0d status=%0d last=%0d",
                                 $realtime, oldest.expired_valid, oldest.expired_id,
                                 oldest.status, oldest.last, m_item.expired_valid,
                                 m_item.expired_id, m_item.status, m_item.last);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin : stimulus
        plan_row_t   plan[$];
        in_item_t    cmd;
        int unsigned n;
        int unsigned r;
        int unsigned ins_pct;
        int unsigned tick_pct;

        // Directed part. The first rows hit the empty queue, the unused op
        // code and the error statuses; then a small list is built with equal
        // and zero delays, an entry is pulled from the middle, the tail and
        // the head, and ticks and removes run the list dry.
        plan.push_back('{mk_cmd(OP_TICK, 4'd0, '0), 1'b1, mk_beat(1'b0, 4'd0, ST_OK, 1'b1)});
        plan.push_back('{mk_cmd(OP_REMOVE, 4'd5, '0), 1'b1,
                         mk_beat(1'b0, 4'd0, ST_ABSENT, 1'b1)});
        plan.push_back('{mk_cmd(OP_SPARE, 4'd15, {DELAY_W{1'b1}}), 1'b1,
                         mk_beat(1'b0, 4'd0, ST_OK, 1'b1)});
        plan.push_back('{mk_cmd(OP_INSERT, 4'd0, '0), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_INSERT, 4'd15, {DELAY_W{1'b1}}), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_INSERT, 4'd0, 31'd9), 1'b1,
                         mk_beat(1'b0, 4'd0, ST_QUEUED, 1'b1)});
        plan.push_back('{mk_cmd(OP_INSERT, 4'd3, 31'd2), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_INSERT, 4'd4, 31'd2), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_INSERT, 4'd7, '0), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_INSERT, 4'd8, 31'd1), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_TICK, 4'd0, '0), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_REMOVE, 4'd3, '0), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_TICK, 4'd9, {DELAY_W{1'b1}}), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_TICK, 4'd0, '0), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_REMOVE, 4'd15, '0), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_REMOVE, 4'd15, '0), 1'b1,
                         mk_beat(1'b0, 4'd0, ST_ABSENT, 1'b1)});
        plan.push_back('{mk_cmd(OP_INSERT, 4'd1, 31'd5), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_INSERT, 4'd2, 31'd3), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_REMOVE, 4'd2, '0), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_REMOVE, 4'd1, {DELAY_W{1'b1}}), 1'b0, '0});
        plan.push_back('{mk_cmd(OP_TICK, 4'd0, '0), 1'b0, '0});

        // Reset is held at the start and then released for good.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            send_cmd(plan[i].cmd, plan[i].has_want, plan[i].want);
        end
        drain_results();

        // Random part. The mix shifts every fifty commands between balanced,
        // tick-heavy and fill-heavy phases, so the list both fills up to all
        // sixteen slots and gets emptied by long expiring ticks.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            case ((n / 50) % 4)
                0:       begin ins_pct = 55; tick_pct = 25; end
                1:       begin ins_pct = 40; tick_pct = 35; end
                2:       begin ins_pct = 25; tick_pct = 55; end
                default: begin ins_pct = 75; tick_pct = 10; end
            endcase
            r                 = $urandom_range(99);
            cmd.waiter_id     = ID_W'($urandom_range(15));
            cmd.delay_ticks   = DELAY_W'($urandom);
            if (r < ins_pct) begin
                cmd.op          = OP_INSERT;
                cmd.delay_ticks = pick_delay();
            end else if (r < ins_pct + tick_pct) begin
                cmd.op = OP_TICK;
            end else if (r < 96) begin
                cmd.op = OP_REMOVE;
                // Most removes name a waiter that is actually queued.
                if (wl_count > 0 && $urandom_range(9) < 7) begin
                    cmd.waiter_id = wl_id[$urandom_range(wl_count - 1)];
                end
            end else begin
                cmd.op = OP_SPARE;
            end
            send_cmd(cmd, 1'b0, '0);
        end

        // Wait for the last beats, then give the block time to show any
        // stray beat before judging the run.
        s_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (fault_count == 0 && due_beats.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== delta_timeout_queue.f =====
rtl/dtq_pkg.sv
rtl/dtq_alu.sv
rtl/delta_timeout_queue.sv
tb/testbench.sv
